// ===== sv/cua_pkg.sv =====
// ----------------------------------------------------------------------------
// cua_pkg: shared types and constants of the contiguous unit allocator
// Field widths, command and policy codes, register indexes and the control
// and flag groups passed between the sequencer and the scan unit.
// ----------------------------------------------------------------------------
package cua_pkg;

  // default sizing of the unit map
  localparam int DEF_MEM_UNITS  = 128;
  localparam int DEF_LABEL_BITS = 8;

  // fixed port field widths
  localparam int OP_W      = 2;
  localparam int LABEL_W   = 8;
  localparam int LEN_W     = 8;
  localparam int START_W   = 7;
  localparam int COUNT_W   = 8;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 8;
  localparam int MODE_W    = 2;

  // command codes
  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_FIND    = 2'd2
  } op_t;

  // placement policies
  typedef enum logic [MODE_W-1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_NEXT  = 2'd2
  } fit_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNITS    = 1'b1;

  // register reset values
  localparam logic [MODE_W-1:0]    FIT_MODE_RST = FIT_FIRST;
  localparam logic [CFG_DAT_W-1:0] UNITS_RST    = 8'd128;

  // result status codes
  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FAIL = 1'b1;

  // per-cycle control of the scan unit
  typedef struct packed {
    logic clear;      // start of a new command
    logic step;       // one unit owner is presented
    logic last;       // the presented unit is the last managed one
    logic count_all;  // count every label hit, not only the first run
  } scan_ctl_t;

  // what the scan has found so far
  typedef struct packed {
    logic ff_found;   // lowest fitting start seen
    logic hi_found;   // fitting start at or above the pointer seen
    logic best_found; // some maximal free run is long enough
    logic lab_seen;   // label present
  } scan_flags_t;

endpackage

// ===== sv/cua_map.sv =====
// ----------------------------------------------------------------------------
// cua_map: unit owner store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cua_map #(
  parameter int MEM_UNITS  = cua_pkg::DEF_MEM_UNITS,
  parameter int LABEL_BITS = cua_pkg::DEF_LABEL_BITS,
  localparam int IW = $clog2(MEM_UNITS)
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [IW-1:0]         wr_addr,
  input  logic [LABEL_BITS-1:0] wr_data,
  input  logic                  rd_en,
  input  logic [IW-1:0]         rd_addr,
  output logic [LABEL_BITS-1:0] rd_data
);

  logic [LABEL_BITS-1:0] mem [MEM_UNITS];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/cua_scan.sv =====
// ----------------------------------------------------------------------------
// cua_scan: per-unit run tracker
// Takes one unit owner per cycle while step is high and keeps free-run, fit and
// label statistics for first, next and best fit and for release and find.
// ----------------------------------------------------------------------------
module cua_scan #(
  parameter int MEM_UNITS  = cua_pkg::DEF_MEM_UNITS,
  parameter int LABEL_BITS = cua_pkg::DEF_LABEL_BITS,
  localparam int IW = $clog2(MEM_UNITS),
  localparam int CW = $clog2(MEM_UNITS + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cua_pkg::scan_ctl_t     ctl,
  input  logic [IW-1:0]          idx,
  input  logic [LABEL_BITS-1:0]  owner,
  input  logic [LABEL_BITS-1:0]  label,
  input  logic [CW-1:0]          len,
  input  logic [IW-1:0]          ptr,
  output logic                   rel_hit,
  output cua_pkg::scan_flags_t   flags,
  output logic [IW-1:0]          ff_start,
  output logic [IW-1:0]          hi_start,
  output logic [IW-1:0]          best_start,
  output logic [IW-1:0]          lab_start,
  output logic [CW-1:0]          lab_cnt
);
  import cua_pkg::*;

  logic [CW-1:0] run_len_r;
  logic [IW-1:0] run_beg_r;
  logic [CW-1:0] hi_len_r;
  logic [IW-1:0] hi_beg_r;
  logic [CW-1:0] best_len_r;
  logic          rel_done_r;
  scan_flags_t   flags_r;
  logic [IW-1:0] ff_start_r;
  logic [IW-1:0] hi_start_r;
  logic [IW-1:0] best_start_r;
  logic [IW-1:0] lab_start_r;
  logic [CW-1:0] lab_cnt_r;

  logic          unit_free;
  logic          unit_match;
  logic          at_or_above;
  logic [CW-1:0] run_new;
  logic [IW-1:0] run_beg;
  logic [CW-1:0] hi_new;
  logic [IW-1:0] hi_beg;
  logic          run_close;
  logic [CW-1:0] close_len;
  logic          best_upd;
  logic          cnt_inc;

  // unit classification
  assign unit_free   = (owner == '0);
  assign unit_match  = (owner == label);
  assign at_or_above = (idx >= ptr);

  // free run through this unit, and the part of it at or above the pointer
  assign run_new = unit_free ? run_len_r + 1'b1 : '0;
  assign run_beg = (run_len_r == '0) ? idx : run_beg_r;
  assign hi_new  = (unit_free && at_or_above) ? hi_len_r + 1'b1 : '0;
  assign hi_beg  = (hi_len_r == '0) ? idx : hi_beg_r;

  // a maximal run ends at an owned unit or at the last managed unit
  assign run_close = (!unit_free && run_len_r != '0) || (unit_free && ctl.last);
  assign close_len = unit_free ? run_new : run_len_r;
  assign best_upd  = run_close && close_len >= len &&
                     (!flags_r.best_found || close_len < best_len_r);

  // label hits: a release takes only the first run
  assign rel_hit = ctl.step && unit_match && !rel_done_r;
  assign cnt_inc = ctl.step && unit_match && (ctl.count_all || !rel_done_r);

  // control flags, run lengths and the label count
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      flags_r    <= '0;
      rel_done_r <= 1'b0;
      run_len_r  <= '0;
      hi_len_r   <= '0;
      lab_cnt_r  <= '0;
    end else if (ctl.step) begin
      run_len_r <= run_new;
      hi_len_r  <= hi_new;
      if (unit_free && !flags_r.ff_found && run_new >= len) begin
        flags_r.ff_found <= 1'b1;
      end
      if (unit_free && at_or_above && !flags_r.hi_found && hi_new >= len) begin
        flags_r.hi_found <= 1'b1;
      end
      if (best_upd) begin
        flags_r.best_found <= 1'b1;
      end
      if (unit_match) begin
        flags_r.lab_seen <= 1'b1;
      end
      if (flags_r.lab_seen && !unit_match) begin
        rel_done_r <= 1'b1;
      end
      if (cnt_inc) begin
        lab_cnt_r <= lab_cnt_r + 1'b1;
      end
    end
  end

  // positions and lengths
  always_ff @(posedge clk) begin
    if (ctl.step) begin
      run_beg_r <= run_beg;
      hi_beg_r  <= hi_beg;
      if (unit_free && !flags_r.ff_found && run_new >= len) begin
        ff_start_r <= run_beg;
      end
      if (unit_free && at_or_above && !flags_r.hi_found && hi_new >= len) begin
        hi_start_r <= hi_beg;
      end
      if (best_upd) begin
        best_start_r <= run_beg;
        best_len_r   <= close_len;
      end
      if (unit_match && !flags_r.lab_seen) begin
        lab_start_r <= idx;
      end
    end
  end

  assign flags      = flags_r;
  assign ff_start   = ff_start_r;
  assign hi_start   = hi_start_r;
  assign best_start = best_start_r;
  assign lab_start  = lab_start_r;
  assign lab_cnt    = lab_cnt_r;

endmodule

// ===== sv/contiguous_unit_allocator.sv =====
// ----------------------------------------------------------------------------
// contiguous_unit_allocator: first, best and next fit unit allocator
// An allocate request scans the managed units and then fills the granted stretch
// on a grant; release and find scan the managed units. Commands with a zero label
// or an unusable length answer without a scan. One command at a time.
// The scan reads one unit per cycle from the single-read-port owner store.
// Reset: a clearing pass writes every unit free with busy high;
// results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module contiguous_unit_allocator #(
  parameter int MEM_UNITS  = cua_pkg::DEF_MEM_UNITS,
  parameter int LABEL_BITS = cua_pkg::DEF_LABEL_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // command transfer
  input  logic                            start,
  output logic                            busy,
  input  logic [cua_pkg::OP_W-1:0]        in_operation,
  input  logic [cua_pkg::LABEL_W-1:0]     in_label_id,
  input  logic [cua_pkg::LEN_W-1:0]       in_request_length,
  // result transfer
  output logic                            out_valid,
  output logic                            out_status,
  output logic [cua_pkg::START_W-1:0]     out_start_unit,
  output logic [cua_pkg::COUNT_W-1:0]     out_unit_count,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cua_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cua_pkg::CFG_DAT_W-1:0]   cfg_wdata
);
  import cua_pkg::*;

  localparam int IW  = $clog2(MEM_UNITS);
  localparam int CW  = $clog2(MEM_UNITS + 1);
  localparam int NW  = (CW > CFG_DAT_W) ? CW : CFG_DAT_W;
  localparam int LWW = LABEL_BITS + LABEL_W;
  localparam int SWW = IW + START_W;
  localparam int KWW = CW + COUNT_W;

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_SCAN   = 7'b0000100,
    S_TAIL   = 7'b0001000,
    S_DECIDE = 7'b0010000,
    S_FILL   = 7'b0100000,
    S_RESP   = 7'b1000000
  } state_t;

  state_t                state_r, state_nxt;
  logic [MODE_W-1:0]     fit_mode_r;
  logic [CFG_DAT_W-1:0]  units_r;
  logic [IW-1:0]         next_ptr_r;

  logic [OP_W-1:0]       op_r;
  logic [LABEL_BITS-1:0] label_r;
  logic [CW-1:0]         len_r;
  logic [IW-1:0]         last_idx_r;
  logic [IW-1:0]         ptr_r;

  logic [IW-1:0]         clr_idx_r;
  logic [IW-1:0]         rd_idx_r;
  logic                  step_vld_r;
  logic                  step_last_r;
  logic [IW-1:0]         step_idx_r;
  logic [IW-1:0]         fill_idx_r;
  logic [CW-1:0]         fill_cnt_r;

  logic                  res_status_r;
  logic [IW-1:0]         res_start_r;
  logic [CW-1:0]         res_count_r;

  logic                  accept;
  logic [NW-1:0]         units_ext;
  logic [NW-1:0]         n_calc;
  logic [NW-1:0]         len_ext;
  logic [LWW-1:0]        label_wide;
  logic [LABEL_BITS-1:0] in_label;
  logic                  early_fail;
  logic [IW-1:0]         ptr_calc;

  logic                  mem_wr_en;
  logic [IW-1:0]         mem_wr_addr;
  logic [LABEL_BITS-1:0] mem_wr_data;
  logic                  mem_rd_en;
  logic [LABEL_BITS-1:0] mem_rd_data;

  scan_ctl_t             scan_ctl;
  scan_flags_t           scan_flags;
  logic                  rel_hit;
  logic [IW-1:0]         ff_start;
  logic [IW-1:0]         hi_start;
  logic [IW-1:0]         best_start;
  logic [IW-1:0]         lab_start;
  logic [CW-1:0]         lab_cnt;

  logic                  grant_ok;
  logic [IW-1:0]         grant_start;
  logic [SWW-1:0]        start_wide;
  logic [KWW-1:0]        count_wide;

  // command transfer and configuration handshake
  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_mode_r <= FIT_MODE_RST;
      units_r    <= UNITS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FIT_MODE: fit_mode_r <= cfg_wdata[MODE_W-1:0];
        CFG_UNITS:    units_r    <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  // managed count, clamped to 1..MEM_UNITS
  assign units_ext = NW'(units_r);
  always_comb begin
    if (units_r == '0) begin
      n_calc = NW'(1);
    end else if (units_ext > NW'(MEM_UNITS)) begin
      n_calc = NW'(MEM_UNITS);
    end else begin
      n_calc = units_ext;
    end
  end

  // command checks done before any scan
  assign len_ext    = NW'(in_request_length);
  assign label_wide = LWW'(in_label_id);
  assign in_label   = label_wide[LABEL_BITS-1:0];
  assign ptr_calc   = (NW'(next_ptr_r) < n_calc) ? next_ptr_r : '0;

  always_comb begin
    unique case (in_operation)
      OP_ALLOC:   early_fail = (in_label == '0) || (in_request_length == '0) ||
                               (len_ext > n_calc);
      OP_RELEASE: early_fail = (in_label == '0);
      OP_FIND:    early_fail = (in_label == '0);
      default:    early_fail = 1'b1;
    endcase
  end

  // command registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r       <= in_operation;
      label_r    <= in_label;
      len_r      <= len_ext[CW-1:0];
      last_idx_r <= IW'(n_calc - NW'(1));
      ptr_r      <= ptr_calc;
    end
  end

  // placement choice at the end of the scan
  always_comb begin
    unique case (fit_mode_r)
      FIT_BEST: begin
        grant_ok    = scan_flags.best_found;
        grant_start = best_start;
      end
      FIT_NEXT: begin
        grant_ok    = scan_flags.hi_found || scan_flags.ff_found;
        grant_start = scan_flags.hi_found ? hi_start : ff_start;
      end
      default: begin
        grant_ok    = scan_flags.ff_found;
        grant_start = ff_start;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:  if (clr_idx_r == IW'(MEM_UNITS - 1)) state_nxt = S_IDLE;
      S_IDLE:   if (accept) state_nxt = early_fail ? S_RESP : S_SCAN;
      S_SCAN:   if (rd_idx_r == last_idx_r) state_nxt = S_TAIL;
      S_TAIL:   state_nxt = S_DECIDE;
      S_DECIDE: state_nxt = (op_r == OP_ALLOC && grant_ok) ? S_FILL : S_RESP;
      S_FILL:   if (fill_cnt_r == CW'(1)) state_nxt = S_RESP;
      S_RESP:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // clearing pass index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
    end else if (state_r == S_CLEAR) begin
      clr_idx_r <= clr_idx_r + 1'b1;
    end
  end

  // read address walk and step pipeline behind the store read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_vld_r  <= 1'b0;
      step_last_r <= 1'b0;
    end else begin
      step_vld_r  <= (state_r == S_SCAN);
      step_last_r <= (state_r == S_SCAN) && (rd_idx_r == last_idx_r);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_idx_r <= '0;
    end else if (state_r == S_SCAN) begin
      rd_idx_r <= rd_idx_r + 1'b1;
    end
    step_idx_r <= rd_idx_r;
  end

  // fill walk over the granted stretch
  always_ff @(posedge clk) begin
    if (state_r == S_DECIDE) begin
      fill_idx_r <= grant_start;
      fill_cnt_r <= len_r;
    end else if (state_r == S_FILL) begin
      fill_idx_r <= fill_idx_r + 1'b1;
      fill_cnt_r <= fill_cnt_r - 1'b1;
    end
  end

  // next fit pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_ptr_r <= '0;
    end else if (state_r == S_DECIDE && op_r == OP_ALLOC && grant_ok &&
                 fit_mode_r == FIT_NEXT) begin
      next_ptr_r <= grant_start;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (accept) begin
      res_status_r <= ST_FAIL;
      res_start_r  <= '0;
      res_count_r  <= '0;
    end else if (state_r == S_DECIDE) begin
      if (op_r == OP_ALLOC) begin
        if (grant_ok) begin
          res_status_r <= ST_OK;
          res_start_r  <= grant_start;
          res_count_r  <= len_r;
        end
      end else if (scan_flags.lab_seen) begin
        res_status_r <= ST_OK;
        res_start_r  <= lab_start;
        res_count_r  <= lab_cnt;
      end
    end
  end

  assign start_wide     = SWW'(res_start_r);
  assign count_wide     = KWW'(res_count_r);
  assign out_valid      = (state_r == S_RESP);
  assign out_status     = res_status_r;
  assign out_start_unit = start_wide[START_W-1:0];
  assign out_unit_count = count_wide[COUNT_W-1:0];

  // store write port: clearing pass, release, fill
  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = clr_idx_r;
    mem_wr_data = '0;
    priority if (state_r == S_CLEAR) begin
      mem_wr_en = 1'b1;
    end else if (state_r == S_FILL) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = fill_idx_r;
      mem_wr_data = label_r;
    end else if (rel_hit && op_r == OP_RELEASE) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = step_idx_r;
    end else begin
      mem_wr_en   = 1'b0;
    end
  end

  assign mem_rd_en = (state_r == S_SCAN);

  cua_map #(
    .MEM_UNITS  (MEM_UNITS),
    .LABEL_BITS (LABEL_BITS)
  ) u_map (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (rd_idx_r),
    .rd_data (mem_rd_data)
  );

  // scan unit control
  assign scan_ctl.clear     = accept;
  assign scan_ctl.step      = step_vld_r;
  assign scan_ctl.last      = step_last_r;
  assign scan_ctl.count_all = (op_r == OP_FIND);

  cua_scan #(
    .MEM_UNITS  (MEM_UNITS),
    .LABEL_BITS (LABEL_BITS)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (scan_ctl),
    .idx        (step_idx_r),
    .owner      (mem_rd_data),
    .label      (label_r),
    .len        (len_r),
    .ptr        (ptr_r),
    .rel_hit    (rel_hit),
    .flags      (scan_flags),
    .ff_start   (ff_start),
    .hi_start   (hi_start),
    .best_start (best_start),
    .lab_start  (lab_start),
    .lab_cnt    (lab_cnt)
  );

`ifndef NO_ASSERTIONS
  // a result strobe lasts one cycle and the block is busy while it shows
  a_resp_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_resp_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result shown while idle");

  // an accepted command keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("not busy after command transfer");

  // the store is never written while idle
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> !mem_wr_en)
    else $error("unit map written while idle");

  // grant write only after a successful fit decision
  a_fill_after_grant: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == S_FILL) |-> $past(grant_ok) && $past(op_r == OP_ALLOC))
    else $error("fill without a grant");
`endif

endmodule

// ===== tb/contiguous_unit_allocator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// contiguous_unit_allocator_tb: self-checking bench for the unit allocator
// Drives allocate, release and find commands under first, best and next fit
// and under several managed unit counts. A behavioral copy of the unit map
// predicts every reply, and each strobed reply is compared with the oldest
// pending prediction. Directed cases come first, then random traffic over a
// small label pool with random gaps on the command side.
// ----------------------------------------------------------------------------
module contiguous_unit_allocator_tb;
  import cua_pkg::*;

  // codes outside the defined sets, still reachable on the ports
  localparam logic [OP_W-1:0]   OP_UNKNOWN  = 2'd3;
  localparam logic [MODE_W-1:0] FIT_UNKNOWN = 2'd3;
  localparam int MAP_UNITS  = DEF_MEM_UNITS;
  localparam int MAX_REPORT = 10;
  localparam int TAIL_WAIT  = 400;

  typedef struct packed {
    logic               status;
    logic [START_W-1:0] start_unit;
    logic [COUNT_W-1:0] unit_count;
  } alloc_reply_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [OP_W-1:0]      in_operation = '0;
  logic [LABEL_W-1:0]   in_label_id = '0;
  logic [LEN_W-1:0]     in_request_length = '0;
  logic                 out_valid;
  logic                 out_status;
  logic [START_W-1:0]   out_start_unit;
  logic [COUNT_W-1:0]   out_unit_count;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;

  // shadow of the allocator state
  logic [LABEL_W-1:0]   owner_map [MAP_UNITS];
  logic [START_W-1:0]   rover;
  logic [MODE_W-1:0]    policy;
  logic [CFG_DAT_W-1:0] managed_cfg;

  alloc_reply_t pending_replies [$];
  int           mismatch_count = 0;
  bit           gaps_on = 1'b1;

  contiguous_unit_allocator i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_operation      (in_operation),
    .in_label_id       (in_label_id),
    .in_request_length (in_request_length),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_start_unit    (out_start_unit),
    .out_unit_count    (out_unit_count),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  // 50 MHz clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #50_000_000;
    $display("contiguous_unit_allocator: mismatch");
    $finish;
  end

  // true when units s..s+len-1 are all free and inside the managed range
  function automatic bit stretch_is_free(int s, int len, int n);
    if (s + len > n) return 1'b0;
    for (int k = s; k < s + len; k++)
      if (owner_map[k] != '0) return 1'b0;
    return 1'b1;
  endfunction

  // next reply of the allocator; updates the shadow map
  function automatic alloc_reply_t predict_reply(logic [OP_W-1:0] op,
                                                 logic [LABEL_W-1:0] label,
                                                 logic [LEN_W-1:0] len);
    alloc_reply_t r;
    int n;
    int s;
    int i;
    int k;
    int p;
    int cand;
    int run;
    int run_start;
    int best_len;
    bit seen;
    r = '{status: ST_FAIL, start_unit: '0, unit_count: '0};
    n = (managed_cfg == 0) ? 1 : ((managed_cfg > MAP_UNITS) ? MAP_UNITS : managed_cfg);
    if (op == OP_ALLOC) begin
      if (label != 0 && len != 0 && len <= n) begin
        s = -1;
        if (policy == FIT_BEST) begin
          best_len = 0;
          i = 0;
          while (i < n) begin
            if (owner_map[i] == '0) begin
              run_start = i;
              run = 0;
              while (i < n && owner_map[i] == '0) begin
                run++;
                i++;
              end
              if (run >= len && (s < 0 || run < best_len)) begin
                s = run_start;
                best_len = run;
              end
            end else begin
              i++;
            end
          end
        end else if (policy == FIT_NEXT) begin
          p = (rover < n) ? rover : 0;
          for (k = 0; k < n; k++) begin
            cand = p + k;
            if (cand >= n) cand -= n;
            if (stretch_is_free(cand, len, n)) begin
              s = cand;
              break;
            end
          end
        end else begin
          for (k = 0; k < n; k++) begin
            if (stretch_is_free(k, len, n)) begin
              s = k;
              break;
            end
          end
        end
        if (s >= 0) begin
          for (i = s; i < s + len; i++) owner_map[i] = label;
          if (policy == FIT_NEXT) rover = s[START_W-1:0];
          r.status = ST_OK;
          r.start_unit = s[START_W-1:0];
          r.unit_count = len;
        end
      end
    end else if (op == OP_RELEASE) begin
      if (label != 0) begin
        for (i = 0; i < n; i++) begin
          if (owner_map[i] == label) begin
            r.start_unit = i[START_W-1:0];
            while (i < n && owner_map[i] == label) begin
              owner_map[i] = '0;
              r.unit_count++;
              i++;
            end
            r.status = ST_OK;
            break;
          end
        end
      end
    end else if (op == OP_FIND) begin
      if (label != 0) begin
        seen = 1'b0;
        for (i = 0; i < n; i++) begin
          if (owner_map[i] == label) begin
            if (!seen) r.start_unit = i[START_W-1:0];
            seen = 1'b1;
            r.unit_count++;
          end
        end
        if (seen) r.status = ST_OK;
      end
    end
    return r;
  endfunction

  task automatic flag_mismatch(string what, alloc_reply_t want, alloc_reply_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORT)
      $display("%0t %s: expected status %0d start %0d count %0d, got status %0d start %0d count %0d",
               $time, what, want.status, want.start_unit, want.unit_count,
               got.status, got.start_unit, got.unit_count);
  endtask

  // compare every strobed reply with the oldest prediction
  always @(posedge clk) begin : check_replies
    alloc_reply_t got;
    alloc_reply_t want;
    if (rst_n && out_valid) begin
      got = '{status: out_status, start_unit: out_start_unit, unit_count: out_unit_count};
      if (pending_replies.size() == 0) begin
        flag_mismatch("unexpected reply", '0, got);
      end else begin
        want = pending_replies.pop_front();
        if (got.status !== want.status || got.start_unit !== want.start_unit ||
            got.unit_count !== want.unit_count)
          flag_mismatch("reply mismatch", want, got);
      end
    end
  end

  // one command transfer; start stays high unless a gap follows
  task automatic issue_command(input logic [OP_W-1:0] op, input logic [LABEL_W-1:0] label,
                               input logic [LEN_W-1:0] len);
    in_operation <= op;
    in_label_id <= label;
    in_request_length <= len;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pending_replies.push_back(predict_reply(op, label, len));
    if (gaps_on && $urandom_range(0, 99) < 10) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 200)) @(posedge clk);
    end
  endtask

  // stop issuing and wait until every reply is back and the block is free
  task automatic drain;
    start <= 1'b0;
    while (pending_replies.size() != 0 || busy) @(posedge clk);
  endtask

  // write both registers while the block is idle
  task automatic reconfigure(input logic [MODE_W-1:0] mode, input logic [CFG_DAT_W-1:0] units);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_FIT_MODE;
    cfg_wdata <= CFG_DAT_W'(mode);
    do @(posedge clk); while (!cfg_ready);
    policy = mode;
    cfg_index <= CFG_UNITS;
    cfg_wdata <= units;
    do @(posedge clk); while (!cfg_ready);
    managed_cfg = units;
    cfg_valid <= 1'b0;
  endtask

  // full map, zero and oversized lengths, reserved label, holes too small
  task automatic test_first_fit;
    reconfigure(FIT_FIRST, 8'd128);
    issue_command(OP_ALLOC, 8'd1, 8'd128);
    issue_command(OP_FIND, 8'd1, 8'd0);
    issue_command(OP_RELEASE, 8'd1, 8'd0);
    issue_command(OP_ALLOC, 8'd2, 8'd0);
    issue_command(OP_ALLOC, 8'd2, 8'd129);
    issue_command(OP_ALLOC, 8'd0, 8'd4);
    issue_command(OP_ALLOC, 8'd255, 8'd5);
    issue_command(OP_ALLOC, 8'd3, 8'd3);
    issue_command(OP_RELEASE, 8'd255, 8'd0);
    issue_command(OP_ALLOC, 8'd4, 8'd6);
    issue_command(OP_FIND, 8'd9, 8'd0);
    issue_command(OP_RELEASE, 8'd0, 8'd0);
    issue_command(OP_UNKNOWN, 8'd3, 8'd255);
  endtask

  // two best fit grants to one label, then find and release of that label
  task automatic test_best_fit;
    reconfigure(FIT_BEST, 8'd128);
    issue_command(OP_ALLOC, 8'd5, 8'd4);
    issue_command(OP_ALLOC, 8'd5, 8'd2);
    issue_command(OP_FIND, 8'd5, 8'd0);
    issue_command(OP_RELEASE, 8'd5, 8'd0);
  endtask

  // pointer moves with grants, no wrap of a stretch, stale pointer
  task automatic test_next_fit;
    reconfigure(FIT_NEXT, 8'd40);
    issue_command(OP_ALLOC, 8'd6, 8'd10);
    issue_command(OP_ALLOC, 8'd7, 8'd20);
    issue_command(OP_ALLOC, 8'd7, 8'd5);
    reconfigure(FIT_NEXT, 8'd20);
    issue_command(OP_ALLOC, 8'd8, 8'd2);
  endtask

  // unknown policy, zero and saturated unit counts
  task automatic test_odd_settings;
    reconfigure(FIT_UNKNOWN, 8'd0);
    issue_command(OP_RELEASE, 8'd8, 8'd0);
    issue_command(OP_ALLOC, 8'd9, 8'd1);
    issue_command(OP_ALLOC, 8'd10, 8'd2);
    reconfigure(FIT_BEST, 8'd255);
    issue_command(OP_FIND, 8'd3, 8'd0);
  endtask

  // mixed traffic over a small label pool, phase by phase
  task automatic test_random_traffic;
    logic [MODE_W-1:0]    phase_mode  [8];
    logic [CFG_DAT_W-1:0] phase_units [8];
    logic [OP_W-1:0]      op;
    logic [LABEL_W-1:0]   label;
    logic [LEN_W-1:0]     len;
    int                   pick;
    phase_mode  = '{FIT_FIRST, FIT_BEST, FIT_NEXT, FIT_NEXT, FIT_BEST, FIT_UNKNOWN,
                    FIT_FIRST, MODE_W'($urandom_range(0, 3))};
    phase_units = '{8'd128, 8'd128, 8'd128, 8'd24, 8'd64, 8'd200, 8'd1,
                    CFG_DAT_W'($urandom_range(0, 255))};
    for (int ph = 0; ph < 8; ph++) begin
      reconfigure(phase_mode[ph], phase_units[ph]);
      gaps_on = (ph != 2);
      for (int j = 0; j < 100; j++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) op = OP_ALLOC;
        else if (pick < 75) op = OP_RELEASE;
        else if (pick < 95) op = OP_FIND;
        else op = OP_UNKNOWN;
        label = ($urandom_range(0, 9) == 0) ? LABEL_W'($urandom_range(0, 255))
                                            : LABEL_W'($urandom_range(1, 8));
        pick = $urandom_range(0, 19);
        if (pick == 0) len = LEN_W'($urandom_range(0, 255));
        else if (pick < 3) len = LEN_W'($urandom_range(1, 128));
        else len = LEN_W'($urandom_range(1, 12));
        issue_command(op, label, len);
      end
    end
    gaps_on = 1'b1;
  endtask

  // reset, tests in turn, final verdict
  initial begin
    for (int i = 0; i < MAP_UNITS; i++) owner_map[i] = '0;
    rover = '0;
    policy = FIT_MODE_RST;
    managed_cfg = UNITS_RST;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_first_fit();
    test_best_fit();
    test_next_fit();
    test_odd_settings();
    test_random_traffic();
    drain();
    repeat (TAIL_WAIT) @(posedge clk);
    while (pending_replies.size() != 0)
      flag_mismatch("missing reply", pending_replies.pop_front(), '0);
    if (mismatch_count == 0) begin
      $display("contiguous_unit_allocator: match");
    end else begin
      $display("contiguous_unit_allocator: mismatch");
    end
    $finish;
  end

endmodule

// ===== contiguous_unit_allocator.f =====
sv/cua_pkg.sv
sv/cua_map.sv
sv/cua_scan.sv
sv/contiguous_unit_allocator.sv
tb/contiguous_unit_allocator_tb.sv
